>>> rtl/image_rotate_nearest_unit_macros.svh
// assertion helpers used by the checker file
`ifndef IMAGE_ROTATE_NEAREST_UNIT_MACROS_SVH
`define IMAGE_ROTATE_NEAREST_UNIT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define IRN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define IRN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/irn_pkg.sv
`default_nettype none

package irn_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COEFF_W    = 16;
    localparam int COEFF_FRAC = 14;
    localparam int DIM_W      = 10;
    localparam int COORD_W    = 9;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // half-pixel offsets, products and sums of the mapping
    localparam int DIFF_W     = DIM_W + 2;
    localparam int PROD_W     = DIFF_W + COEFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_BITS  = COEFF_FRAC + 1;
    localparam int SRC_W      = SUM_W - FRAC_BITS;

    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_SIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

    localparam logic signed [COEFF_W-1:0] COS_RESET     = 16'sd16384;
    localparam logic signed [COEFF_W-1:0] NEG_SIN_RESET = 16'sd0;
    localparam logic [DIM_W-1:0]          WIDTH_RESET   = 10'd512;
    localparam logic [DIM_W-1:0]          HEIGHT_RESET  = 10'd512;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   load_value;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_value;
        logic             source_inside;
    } result_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] cos_coeff;
        logic signed [COEFF_W-1:0] neg_sin_coeff;
        logic [DIM_W-1:0]          frame_width;
        logic [DIM_W-1:0]          frame_height;
    } cfg_t;

    // store access leaving the mapping pipeline
    typedef struct packed {
        logic             valid;
        logic             opcode;
        logic             en;
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
        logic [PIX_W-1:0] load_value;
    } st_req_t;

    typedef struct packed {
        logic             valid;
        logic             query;
        logic             hit;
        logic [PIX_W-1:0] pixel;
    } st_rsp_t;

endpackage

`default_nettype wire

>>> rtl/image_rotate_nearest_unit.sv
// a query passes the mapping registers, the store read register and the result register
// throughput: one item per cycle unless stalled; loads and queries share one store port
// a stalled result register holds the whole pipeline, nothing is dropped or repeated
// reset: pipeline valid bits and the result valid bit clear, config registers take their
// reset values; the frame store is not cleared and holds nothing until loaded
`default_nettype none

module image_rotate_nearest_unit
    import irn_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEFF_W-1:0]   cfg_data,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output result_t                   result
);

    cfg_t    cfg_reg;
    st_req_t req;
    st_rsp_t rsp;
    logic    adv;
    logic    result_valid_reg;
    result_t result_reg;

    // the pipeline moves whenever the result register is free or being drained
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_coeff     <= COS_RESET;
            cfg_reg.neg_sin_coeff <= NEG_SIN_RESET;
            cfg_reg.frame_width   <= WIDTH_RESET;
            cfg_reg.frame_height  <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_COS:     cfg_reg.cos_coeff     <= $signed(cfg_data);
                REG_NEG_SIN: cfg_reg.neg_sin_coeff <= $signed(cfg_data);
                REG_WIDTH:   cfg_reg.frame_width   <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:  cfg_reg.frame_height  <= cfg_data[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    irn_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .req        (req)
    );

    irn_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (req),
        .rsp   (rsp)
    );

    // loads end in the store, only queries reach the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= rsp.valid && rsp.query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.out_value     <= rsp.hit ? rsp.pixel : '0;
            result_reg.source_inside <= rsp.hit;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/irn_map.sv
`default_nettype none

module irn_map
    import irn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire logic    item_valid,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output st_req_t      req
);

    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    item_t                     item1_reg, item2_reg, item3_reg;

    logic [DIM_W-1:0]          w_sat, h_sat;
    logic [DIM_W-1:0]          w1_reg, h1_reg, w2_reg, h2_reg, w3_reg, h3_reg;
    logic signed [DIFF_W-1:0]  dx2_next, dy2_next, dx2_reg, dy2_reg;

    logic signed [PROD_W-1:0]  xc_reg, xs_reg, yc_reg, ys_reg;
    logic signed [SUM_W-1:0]   sum_x_next, sum_y_next, sum_x_reg, sum_y_reg;

    logic [SRC_W-1:0]          sx, sy;
    logic                      adj_x, adj_y, src_inside, load_ok;
    logic                      opcode4_reg, en4_reg;
    logic [XW-1:0]             x_next, x4_reg;
    logic [YW-1:0]             y_next, y4_reg;
    logic [PIX_W-1:0]          value4_reg;
    logic                      en_next;

    // frame size saturates to the store size
    always_comb
    begin
        w_sat = (int'(cfg.frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.frame_width;
        h_sat = (int'(cfg.frame_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg.frame_height;
        dx2_next = $signed(DIFF_W'({item.column, 1'b0}) - DIFF_W'(w_sat));
        dy2_next = $signed(DIFF_W'({item.row, 1'b0}) - DIFF_W'(h_sat));
    end

    always_comb
    begin
        sum_x_next = $signed(SUM_W'({w2_reg, {COEFF_FRAC{1'b0}}}))
                   + SUM_W'(ys_reg) + SUM_W'(xc_reg);
        sum_y_next = $signed(SUM_W'({h2_reg, {COEFF_FRAC{1'b0}}}))
                   + SUM_W'(yc_reg) - SUM_W'(xs_reg);
    end

    // truncation toward zero: bump the floor of a negative value with a fraction
    always_comb
    begin
        adj_x = sum_x_reg[SUM_W-1] & (|sum_x_reg[FRAC_BITS-1:0]);
        adj_y = sum_y_reg[SUM_W-1] & (|sum_y_reg[FRAC_BITS-1:0]);
        sx = sum_x_reg[SUM_W-1:FRAC_BITS] + SRC_W'(adj_x);
        sy = sum_y_reg[SUM_W-1:FRAC_BITS] + SRC_W'(adj_y);
        src_inside = !sx[SRC_W-1] && (sx < SRC_W'(w3_reg))
                  && !sy[SRC_W-1] && (sy < SRC_W'(h3_reg));
        load_ok = (int'(item3_reg.column) < MAX_WIDTH) && (int'(item3_reg.row) < MAX_HEIGHT);
        if (item3_reg.opcode == OP_QUERY)
        begin
            x_next  = XW'(sx);
            y_next  = YW'(sy);
            en_next = src_inside;
        end
        else
        begin
            x_next  = XW'(item3_reg.column);
            y_next  = YW'(item3_reg.row);
            en_next = load_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item1_reg   <= item;
            w1_reg      <= w_sat;
            h1_reg      <= h_sat;
            dx2_reg     <= dx2_next;
            dy2_reg     <= dy2_next;

            item2_reg   <= item1_reg;
            w2_reg      <= w1_reg;
            h2_reg      <= h1_reg;
            xc_reg      <= PROD_W'(dx2_reg) * PROD_W'(cfg.cos_coeff);
            xs_reg      <= PROD_W'(dx2_reg) * PROD_W'(cfg.neg_sin_coeff);
            yc_reg      <= PROD_W'(dy2_reg) * PROD_W'(cfg.cos_coeff);
            ys_reg      <= PROD_W'(dy2_reg) * PROD_W'(cfg.neg_sin_coeff);

            item3_reg   <= item2_reg;
            w3_reg      <= w2_reg;
            h3_reg      <= h2_reg;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;

            opcode4_reg <= item3_reg.opcode;
            en4_reg     <= en_next;
            x4_reg      <= x_next;
            y4_reg      <= y_next;
            value4_reg  <= item3_reg.load_value;
        end
    end

    assign req = '{valid: v4_reg, opcode: opcode4_reg, en: en4_reg,
                   x: x4_reg, y: y4_reg, load_value: value4_reg};

endmodule

`default_nettype wire

>>> rtl/irn_store.sv
`default_nettype none

module irn_store
    import irn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire st_req_t req,
    output st_rsp_t      rsp
);

    logic [PIX_W-1:0]  mem [MAX_WIDTH*MAX_HEIGHT];
    logic [ADDR_W-1:0] addr;
    logic              wr_en;
    logic [PIX_W-1:0]  rd_reg;
    logic              valid_reg, query_reg, inside_reg;

    always_comb
    begin
        addr  = ADDR_W'(req.y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req.x);
        wr_en = req.valid && (req.opcode == OP_LOAD) && req.en;
    end

    // loads and queries share one port, so order is kept
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                mem[addr] <= req.load_value;
            end
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            query_reg  <= (req.opcode == OP_QUERY);
            inside_reg <= req.en;
        end
    end

    assign rsp = '{valid: valid_reg, query: query_reg, hit: inside_reg, pixel: rd_reg};

endmodule

`default_nettype wire

>>> rtl/irn_checker.sv
`default_nettype none

`include "image_rotate_nearest_unit_macros.svh"

module irn_checker
    import irn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_ready,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result
);

    // a stalled result keeps its value
    `IRN_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

    // a source outside the frame always gives a black pixel
    `IRN_ASSERT_NOW(a_outside_zero, clk, rst_n, result_valid && !result.source_inside, result.out_value == '0, "outside source with nonzero value")

    // an empty result register never blocks the input
    `IRN_ASSERT_NOW(a_ready_empty, clk, rst_n, !result_valid, item_ready, "input blocked with no result pending")

    // a result transfer frees the pipeline in the same cycle
    `IRN_ASSERT_NOW(a_ready_drain, clk, rst_n, result_valid && result_ready, item_ready, "input blocked while result drains")

endmodule

bind image_rotate_nearest_unit irn_checker u_irn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
